// ----- src/servo_command_packet_framer_top_defines.svh -----
// Assertion macros for the servo command packet framer.
`ifndef SERVO_COMMAND_PACKET_FRAMER_TOP_DEFINES_SVH
`define SERVO_COMMAND_PACKET_FRAMER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPF_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("servo framer check failed");

// The consequent must hold in the cycle after the antecedent.
`define SPF_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("servo framer check failed");

`endif

// ----- src/spf_pkg.sv -----
package spf_pkg;

	localparam int CFG_IDX_W = 3;
	localparam int IDX_W = 4;
	localparam int DEFAULT_FIFO_DEPTH = 2;

	localparam logic [CFG_IDX_W-1:0] REG_DEVICE_ID = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MOVE_POS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MOVE_SPD = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HOME_POS = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HOME_SPD = 3'd4;

	localparam logic [3:0] RST_DEVICE_ID = 4'd0;
	localparam logic [15:0] RST_MOVE_POS = 16'd600;
	localparam logic [15:0] RST_MOVE_SPD = 16'd100;
	localparam logic [15:0] RST_HOME_POS = 16'd0;
	localparam logic [15:0] RST_HOME_SPD = 16'd300;

	localparam logic [IDX_W-1:0] IDX_PRE0 = 4'd0;
	localparam logic [IDX_W-1:0] IDX_PRE1 = 4'd1;
	localparam logic [IDX_W-1:0] IDX_ID = 4'd2;
	localparam logic [IDX_W-1:0] IDX_LEN = 4'd3;
	localparam logic [IDX_W-1:0] IDX_INSTR = 4'd4;
	localparam logic [IDX_W-1:0] IDX_ADDR = 4'd5;
	localparam logic [IDX_W-1:0] IDX_POS_H = 4'd6;
	localparam logic [IDX_W-1:0] IDX_POS_L = 4'd7;
	localparam logic [IDX_W-1:0] IDX_ZERO = 4'd8;
	localparam logic [IDX_W-1:0] IDX_ONE = 4'd9;
	localparam logic [IDX_W-1:0] IDX_SPD_H = 4'd10;
	localparam logic [IDX_W-1:0] IDX_SPD_L = 4'd11;
	localparam logic [IDX_W-1:0] IDX_CHK = 4'd12;

	localparam logic [7:0] BYTE_PREAMBLE = 8'hFF;
	localparam logic [7:0] BYTE_LENGTH = 8'h09;
	localparam logic [7:0] BYTE_WRITE = 8'h03;
	localparam logic [7:0] BYTE_GOAL_ADDR = 8'h2A;

	typedef struct packed {
		logic [3:0] device_id;
		logic [15:0] move_position;
		logic [15:0] move_speed;
		logic [15:0] home_position;
		logic [15:0] home_speed;
	} cfg_t;

	typedef struct packed {
		logic [1:0] sel;
		logic move;
		logic home;
	} req_t;

endpackage

// ----- src/servo_command_packet_framer_top.sv -----
// Servo command packet framer. A command byte whose upper nibble matches
// device_id with a request bit set becomes one or two 13-byte servo bus
// write packets (move first, then home), sent one byte per transfer on the
// output channel. A command yields 0, 13 or 26 bytes; the back sequencer's
// byte counter emits one byte per cycle unless out_stall holds the output.
// The next queued command is popped as the previous command's last byte is
// registered, so its first byte follows unless stalled. The front takes one
// command per cycle as long as the FIFO_DEPTH-entry request queue has room.
module servo_command_packet_framer_top #(
	parameter int FIFO_DEPTH = spf_pkg::DEFAULT_FIFO_DEPTH
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [7:0] cmd_byte,
	output logic out_valid,
	input logic out_stall,
	output logic [7:0] tx_byte,
	output logic packet_end,
	output logic run_last,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [spf_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [15:0] cfg_wdata
);
	import spf_pkg::*;

	cfg_t cfg;
	req_t push_data;
	req_t pop_data;
	logic q_push;
	logic q_full;
	logic q_pop;
	logic q_not_empty;

	spf_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd_byte(cmd_byte),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.q_full(q_full),
		.q_push(q_push),
		.q_data(push_data),
		.cfg(cfg)
	);

	spf_fifo #(
		.DEPTH(FIFO_DEPTH)
	) u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.push_data(push_data),
		.full(q_full),
		.pop(q_pop),
		.not_empty(q_not_empty),
		.pop_data(pop_data)
	);

	spf_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.q_not_empty(q_not_empty),
		.q_data(pop_data),
		.q_pop(q_pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.tx_byte(tx_byte),
		.packet_end(packet_end),
		.run_last(run_last)
	);

endmodule

// ----- src/spf_front.sv -----
module spf_front (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [7:0] cmd_byte,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [spf_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [15:0] cfg_wdata,
	input logic q_full,
	output logic q_push,
	output spf_pkg::req_t q_data,
	output spf_pkg::cfg_t cfg
);
	import spf_pkg::*;

	cfg_t cfg_q;
	logic match;

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;
	assign in_stall = q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.device_id <= RST_DEVICE_ID;
			cfg_q.move_position <= RST_MOVE_POS;
			cfg_q.move_speed <= RST_MOVE_SPD;
			cfg_q.home_position <= RST_HOME_POS;
			cfg_q.home_speed <= RST_HOME_SPD;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_DEVICE_ID: cfg_q.device_id <= cfg_wdata[3:0];
				REG_MOVE_POS: cfg_q.move_position <= cfg_wdata;
				REG_MOVE_SPD: cfg_q.move_speed <= cfg_wdata;
				REG_HOME_POS: cfg_q.home_position <= cfg_wdata;
				REG_HOME_SPD: cfg_q.home_speed <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Commands for another node or with no request bits produce nothing.
	assign match = (cmd_byte[7:4] == cfg_q.device_id) && (cmd_byte[1:0] != 2'b00);
	assign q_push = in_valid && !in_stall && match;
	assign q_data.sel = cmd_byte[3:2];
	assign q_data.move = cmd_byte[0];
	assign q_data.home = cmd_byte[1];

endmodule

// ----- src/spf_fifo.sv -----
module spf_fifo #(
	parameter int DEPTH = spf_pkg::DEFAULT_FIFO_DEPTH
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input spf_pkg::req_t push_data,
	output logic full,
	input logic pop,
	output logic not_empty,
	output spf_pkg::req_t pop_data
);
	import spf_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	req_t entries_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign full = (count_q == FULL_CNT);
	assign not_empty = (count_q != '0);
	assign do_push = push && !full;
	assign do_pop = pop && not_empty;
	assign pop_data = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- src/spf_back.sv -----
module spf_back (
	input logic clk,
	input logic arst_n,
	input spf_pkg::cfg_t cfg,
	input logic q_not_empty,
	input spf_pkg::req_t q_data,
	output logic q_pop,
	output logic out_valid,
	input logic out_stall,
	output logic [7:0] tx_byte,
	output logic packet_end,
	output logic run_last
);
	import spf_pkg::*;

	logic active_q;
	logic home_phase_q;
	logic need_home_q;
	logic [1:0] sel_q;
	logic [IDX_W-1:0] idx_q;
	logic [7:0] sum_q;
	logic out_valid_q;
	logic [7:0] tx_byte_q;
	logic packet_end_q;
	logic run_last_q;

	logic adv;
	logic at_chk;
	logic more_pkt;
	logic finishing;
	logic [15:0] pos;
	logic [15:0] spd;
	logic [7:0] cur_byte;

	assign adv = !out_valid_q || !out_stall;
	assign at_chk = (idx_q == IDX_CHK);
	assign more_pkt = !home_phase_q && need_home_q;
	assign finishing = active_q && adv && at_chk && !more_pkt;
	assign q_pop = q_not_empty && (!active_q || finishing);

	assign pos = home_phase_q ? cfg.home_position : cfg.move_position;
	assign spd = home_phase_q ? cfg.home_speed : cfg.move_speed;

	always_comb begin
		unique case (idx_q)
			IDX_PRE0, IDX_PRE1: cur_byte = BYTE_PREAMBLE;
			IDX_ID: cur_byte = {6'd0, sel_q} + 8'd1;
			IDX_LEN: cur_byte = BYTE_LENGTH;
			IDX_INSTR: cur_byte = BYTE_WRITE;
			IDX_ADDR: cur_byte = BYTE_GOAL_ADDR;
			IDX_POS_H: cur_byte = pos[15:8];
			IDX_POS_L: cur_byte = pos[7:0];
			IDX_ZERO: cur_byte = 8'h00;
			IDX_ONE: cur_byte = 8'h01;
			IDX_SPD_H: cur_byte = spd[15:8];
			IDX_SPD_L: cur_byte = spd[7:0];
			IDX_CHK: cur_byte = ~sum_q;
			default: cur_byte = 8'h00;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			home_phase_q <= 1'b0;
			need_home_q <= 1'b0;
			sel_q <= '0;
			idx_q <= IDX_PRE0;
			sum_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				out_valid_q <= active_q;
			end
			if (q_pop) begin
				active_q <= 1'b1;
				sel_q <= q_data.sel;
				need_home_q <= q_data.home;
				home_phase_q <= !q_data.move;
				idx_q <= IDX_PRE0;
				sum_q <= '0;
			end else if (active_q && adv) begin
				if (at_chk) begin
					if (more_pkt) begin
						home_phase_q <= 1'b1;
						idx_q <= IDX_PRE0;
						sum_q <= '0;
					end else begin
						active_q <= 1'b0;
					end
				end else begin
					idx_q <= idx_q + 1'b1;
					if (idx_q >= IDX_ID) begin
						sum_q <= sum_q + cur_byte;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && active_q) begin
			tx_byte_q <= cur_byte;
			packet_end_q <= at_chk;
			run_last_q <= at_chk && !more_pkt;
		end
	end

	assign out_valid = out_valid_q;
	assign tx_byte = tx_byte_q;
	assign packet_end = packet_end_q;
	assign run_last = run_last_q;

endmodule

// ----- src/spf_checker.sv -----
`include "servo_command_packet_framer_top_defines.svh"

module spf_checker (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_stall,
	input logic [7:0] tx_byte,
	input logic packet_end,
	input logic run_last
);
	import spf_pkg::*;

	// A stalled output byte stays in place.
	`SPF_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(tx_byte))

	// The last byte of a command always closes a packet.
	`SPF_ASSERT_SAME(a_last_is_end, out_valid && run_last, packet_end)

	// A closed packet that is not the last of its command is followed at once
	// by the preamble of the home packet.
	`SPF_ASSERT_NEXT(a_second_pkt, out_valid && !out_stall && packet_end && !run_last,
		out_valid && (tx_byte == BYTE_PREAMBLE) && !packet_end)

	// Inside a packet each transfer is followed at once by the next byte.
	`SPF_ASSERT_NEXT(a_pkt_gapless, out_valid && !out_stall && !packet_end, out_valid)

endmodule

bind servo_command_packet_framer_top spf_checker u_spf_checker (.*);

// ----- dv/spf_packet_checker.sv -----
`timescale 1ns / 100ps

module spf_packet_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic [7:0] cmd_byte,
	input logic out_valid,
	input logic out_stall,
	input logic [7:0] tx_byte,
	input logic packet_end,
	input logic run_last,
	input logic cfg_valid,
	input logic cfg_ready,
	input logic [spf_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [15:0] cfg_wdata,
	output int mismatches,
	output int bytes_left,
	output int bytes_checked
);
	import spf_pkg::*;

	typedef struct packed {
		logic [7:0] data;
		logic pkt_end;
		logic cmd_end;
	} bus_byte_t;

	cfg_t regs;
	bus_byte_t bytes_due[$];
	bus_byte_t head;

	task automatic queue_packet(input logic [7:0] servo_id, input logic [15:0] pos,
			input logic [15:0] spd, input logic closes_cmd);
		logic [7:0] body [10];
		logic [7:0] sum;
		body = '{servo_id, BYTE_LENGTH, BYTE_WRITE, BYTE_GOAL_ADDR, pos[15:8], pos[7:0],
			8'h00, 8'h01, spd[15:8], spd[7:0]};
		sum = '0;
		bytes_due.push_back(bus_byte_t'{BYTE_PREAMBLE, 1'b0, 1'b0});
		bytes_due.push_back(bus_byte_t'{BYTE_PREAMBLE, 1'b0, 1'b0});
		foreach (body[i]) begin
			sum = sum + body[i];
			bytes_due.push_back(bus_byte_t'{body[i], 1'b0, 1'b0});
		end
		bytes_due.push_back(bus_byte_t'{~sum, 1'b1, closes_cmd});
	endtask

	task automatic frame_command(input logic [7:0] cmd);
		logic [7:0] servo_id;
		servo_id = {6'd0, cmd[3:2]} + 8'd1;
		if (cmd[7:4] == regs.device_id) begin
			if (cmd[0])
				queue_packet(servo_id, regs.move_position, regs.move_speed, !cmd[1]);
			if (cmd[1])
				queue_packet(servo_id, regs.home_position, regs.home_speed, 1'b1);
		end
	endtask

	task automatic check_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s expected %h, actual %h", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs = '{device_id: RST_DEVICE_ID, move_position: RST_MOVE_POS,
				move_speed: RST_MOVE_SPD, home_position: RST_HOME_POS,
				home_speed: RST_HOME_SPD};
			bytes_due.delete();
			mismatches = 0;
			bytes_checked = 0;
			bytes_left = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_DEVICE_ID: regs.device_id = cfg_wdata[3:0];
					REG_MOVE_POS: regs.move_position = cfg_wdata;
					REG_MOVE_SPD: regs.move_speed = cfg_wdata;
					REG_HOME_POS: regs.home_position = cfg_wdata;
					REG_HOME_SPD: regs.home_speed = cfg_wdata;
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				bytes_checked++;
				if (bytes_due.size() == 0) begin
					mismatches++;
					$display("%0t: expected no byte, actual tx_byte %h packet_end %b run_last %b",
						$time, tx_byte, packet_end, run_last);
				end else begin
					head = bytes_due.pop_front();
					check_field("tx_byte", head.data, tx_byte);
					check_field("packet_end", {7'd0, head.pkt_end}, {7'd0, packet_end});
					check_field("run_last", {7'd0, head.cmd_end}, {7'd0, run_last});
				end
			end
			if (in_valid && !in_stall)
				frame_command(cmd_byte);
			bytes_left = bytes_due.size();
		end
	end

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 100ps

module tb;
	import spf_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 40;
	localparam int TAIL_CYCLES = 60;
	localparam int ITEMS_PER_PHASE = 110;
	localparam logic [CFG_IDX_W-1:0] IDX_UNUSED_LO = REG_HOME_SPD + 3'd1;
	localparam logic [CFG_IDX_W-1:0] IDX_UNUSED_HI = '1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic [7:0] cmd_byte = '0;
	logic out_stall = 1'b0;
	logic cfg_valid = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_DEVICE_ID;
	logic [15:0] cfg_wdata = '0;
	logic in_stall;
	logic out_valid;
	logic [7:0] tx_byte;
	logic packet_end;
	logic run_last;
	logic cfg_ready;

	int mismatches;
	int bytes_left;
	int bytes_checked;
	int send_idle_pct = 20;
	int recv_stall_pct = 59;
	int commands_sent = 0;
	int settings_used = 0;
	int quiet_cycles = 0;
	logic [3:0] node = RST_DEVICE_ID;

	always #2 clk = ~clk;

	servo_command_packet_framer_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd_byte(cmd_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.tx_byte(tx_byte),
		.packet_end(packet_end),
		.run_last(run_last),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	spf_packet_checker chk (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd_byte(cmd_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.tx_byte(tx_byte),
		.packet_end(packet_end),
		.run_last(run_last),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.mismatches(mismatches),
		.bytes_left(bytes_left),
		.bytes_checked(bytes_checked)
	);

	always @(posedge clk)
		out_stall <= ($urandom_range(99) < recv_stall_pct);

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: watchdog expired after %0d cycles without a transfer",
				$time, quiet_cycles);
			$display("Mismatches found");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_cmd(input logic [7:0] c);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		cmd_byte <= c;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		commands_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (bytes_left != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == REG_DEVICE_ID)
			node = data[3:0];
		@(posedge clk);
	endtask

	task automatic configure(input logic [15:0] dev, input logic [15:0] mpos,
			input logic [15:0] mspd, input logic [15:0] hpos, input logic [15:0] hspd);
		write_reg(REG_DEVICE_ID, dev);
		write_reg(REG_MOVE_POS, mpos);
		write_reg(REG_MOVE_SPD, mspd);
		write_reg(REG_HOME_POS, hpos);
		write_reg(REG_HOME_SPD, hspd);
		settings_used++;
	endtask

	task automatic random_setting();
		configure(16'($urandom_range(65535)), 16'($urandom_range(65535)),
			16'($urandom_range(65535)), 16'($urandom_range(65535)),
			16'($urandom_range(65535)));
		if ($urandom_range(1) == 1)
			write_reg(CFG_IDX_W'($urandom_range(IDX_UNUSED_LO, IDX_UNUSED_HI)),
				16'($urandom_range(65535)));
	endtask

	initial begin
		logic [7:0] c;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_cmd(8'h01);
		send_cmd(8'h02);
		send_cmd(8'h03);
		send_cmd(8'h0F);
		send_cmd(8'h0C);
		send_cmd(8'h10);
		send_cmd(8'hF3);
		send_cmd(8'h00);
		send_cmd(8'h06);
		drain();

		configure(16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF);
		write_reg(IDX_UNUSED_LO, 16'h1234);
		write_reg(IDX_UNUSED_HI, 16'hFFFF);
		send_cmd(8'hFF);
		send_cmd(8'hF1);
		send_cmd(8'hFA);
		send_cmd(8'h0F);
		send_cmd(8'hF0);
		drain();

		configure(16'hFFF0, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000);
		send_cmd(8'h03);
		send_cmd(8'h0D);
		send_cmd(8'hF3);
		drain();

		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 20 : (phase == 1) ? 59 : 0;
			recv_stall_pct = (phase == 0) ? 59 : (phase == 1) ? 20 : 0;
			random_setting();
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (n == ITEMS_PER_PHASE / 2) begin
					drain();
					random_setting();
				end
				if ($urandom_range(99) < 80)
					c = {node, 4'($urandom_range(15))};
				else
					c = 8'($urandom_range(255));
				send_cmd(c);
			end
			drain();
		end

		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (bytes_left != 0);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Ran %0d commands under %0d register settings and three idle mixes;",
			commands_sent, settings_used);
		$display("%0d packet bytes were compared against the predicted frames.", bytes_checked);
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
